[hw/rtl/strmq_pkg.sv]
package strmq_pkg;

    // Field widths fixed by the interface
    localparam int unsigned OPC_W = 2;
    localparam int unsigned POS_W = 10;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned STS_W = 2;
    localparam int unsigned LEN_W = 11;
    // Width of r - l + 1 for a 10-bit position
    localparam int unsigned SPAN_W = 11;

    // Item opcodes
    localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPC_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OPC_W-1:0] OP_QUERY = 2'd2;

    // Result status codes
    localparam logic [STS_W-1:0] STS_OK  = 2'd0;
    localparam logic [STS_W-1:0] STS_BAD = 2'd1;
    localparam logic [STS_W-1:0] STS_ACK = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_B0_RD,
        S_B0_WR,
        S_LVL,
        S_BK_RDA,
        S_BK_RDB,
        S_BK_WR,
        S_Q_CHK,
        S_Q_RDA,
        S_Q_RDB,
        S_Q_CMP,
        S_FINISH
    } seq_state_t;

    // Control strobes from the sequencer to the table unit
    typedef struct packed {
        logic rd_en;   // read table, data registered
        logic cap_a;   // hold the first read word
        logic wr_en;   // write table
        logic wr_min;  // write data is min of held and read words
    } tbl_ctrl_t;

endpackage

[hw/rtl/strmq_table.sv]
module strmq_table #(
    parameter int DEPTH      = 1024,
    parameter int LEVELS     = 11,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  strmq_pkg::tbl_ctrl_t      ctrl,
    input  logic [$clog2(LEVELS)-1:0] rd_level,
    input  logic [$clog2(DEPTH)-1:0]  rd_idx,
    input  logic [$clog2(LEVELS)-1:0] wr_level,
    input  logic [$clog2(DEPTH)-1:0]  wr_idx,
    input  logic [DATA_WIDTH-1:0]     wr_data,
    output logic [DATA_WIDTH-1:0]     min_out
);

    // Sparse table: row is the level, column the start position
    logic [DATA_WIDTH-1:0] mem [LEVELS][DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] wdata;

    // Shared signed compare: smaller of held word and last read word
    always_comb
    begin
        if ($signed(rdata_reg) < $signed(a_reg))
        begin
            min_out = rdata_reg;
        end
        else
        begin
            min_out = a_reg;
        end
    end

    assign wdata = ctrl.wr_min ? min_out : wr_data;

    // Memory port and operand capture
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_level][wr_idx] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_level][rd_idx];
        end
        if (ctrl.cap_a)
        begin
            a_reg <= rdata_reg;
        end
    end

endmodule

[hw/rtl/sparse_table_range_minimum.sv]
// Channel   | Handshake             | Beat fields
// ----------+-----------------------+-----------------------------------------
// input     | in_valid / in_stall   | opcode, index, right_bound, value
// output    | out_valid / out_stall | minimum, status
// config    | cfg_wr_en             | cfg_wr_data (length)
//
// One item at a time; in_stall is high while an item is in work.
// Load and unused opcodes go straight to hand-off. Query: check, two table reads, compare,
// hand-off; a bad range skips from check to hand-off. Build, n = min(length, DEPTH): level 0
// is copied first, then each level k below LEVELS with 2^k <= n, then hand-off (directly if n is 0).
// rst_n clears control state only; both stores are undefined until written.
// A result that is stalled holds the engine in its final state until taken.
module sparse_table_range_minimum #(
    parameter int DEPTH      = 1024,
    parameter int LEVELS     = 11,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [strmq_pkg::LEN_W-1:0]        cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [strmq_pkg::OPC_W-1:0]        opcode,
    input  logic [strmq_pkg::POS_W-1:0]        index,
    input  logic [strmq_pkg::POS_W-1:0]        right_bound,
    input  logic signed [strmq_pkg::VAL_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [strmq_pkg::VAL_W-1:0] minimum,
    output logic [strmq_pkg::STS_W-1:0]        status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = $clog2(LEVELS);
    localparam int KW = $clog2(LEVELS + 1);
    localparam int SW = ((LEVELS > CW) ? LEVELS : CW) + 1;
    localparam int NW = ((CW > strmq_pkg::LEN_W) ? CW : strmq_pkg::LEN_W) + 1;

    strmq_pkg::seq_state_t state_reg, state_next;
    strmq_pkg::tbl_ctrl_t  ctrl;

    logic [strmq_pkg::LEN_W-1:0]  length_reg;
    logic [CW-1:0]                n_eff;
    logic                         in_acc;
    logic                         out_free;

    logic [CW-1:0]                i_reg;
    logic [KW-1:0]                k_reg;
    logic [SW-1:0]                span_reg;
    logic [strmq_pkg::POS_W-1:0]  l_reg;
    logic [strmq_pkg::POS_W-1:0]  r_reg;
    logic [LW-1:0]                p_reg;
    logic [AW-1:0]                bidx_reg;
    logic [DATA_WIDTH-1:0]        res_min_reg;
    logic [strmq_pkg::STS_W-1:0]  res_sts_reg;
    logic                         out_valid_reg;
    logic [DATA_WIDTH-1:0]        minimum_reg;
    logic [strmq_pkg::STS_W-1:0]  status_reg;

    logic [DATA_WIDTH-1:0]        elem_mem [DEPTH];
    logic [DATA_WIDTH-1:0]        elem_q_reg;

    logic [LW-1:0]                rd_level;
    logic [AW-1:0]                rd_idx;
    logic [LW-1:0]                wr_level;
    logic [DATA_WIDTH-1:0]        min_out;

    logic                         lvl_go;
    logic                         b0_more;
    logic                         bk_more;
    logic                         q_bad;
    logic [strmq_pkg::SPAN_W-1:0] q_span;
    logic [4:0]                   q_log;
    logic [LW-1:0]                q_lvl;
    logic [strmq_pkg::SPAN_W-1:0] q_bidx;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Length saturates at the table depth
    assign n_eff = (NW'(length_reg) > NW'(DEPTH)) ? CW'(DEPTH) : CW'(length_reg);

    // Loop conditions of the build
    assign lvl_go  = (k_reg < KW'(LEVELS)) && (span_reg <= SW'(n_eff));
    assign b0_more = (CW'(i_reg + 1'b1) < n_eff);
    assign bk_more = ((SW'(i_reg) + SW'(1) + span_reg) <= SW'(n_eff));

    // Query range check and level pick
    assign q_bad  = (l_reg > r_reg) || (NW'(r_reg) >= NW'(n_eff));
    assign q_span = strmq_pkg::SPAN_W'(r_reg) - strmq_pkg::SPAN_W'(l_reg) + 1'b1;

    always_comb
    begin
        q_log = '0;
        for (int b = 0; b < strmq_pkg::SPAN_W; b++)
        begin
            if (q_span[b])
            begin
                q_log = 5'(b);
            end
        end
    end

    assign q_lvl  = (q_log >= 5'(LEVELS)) ? LW'(LEVELS - 1) : LW'(q_log);
    assign q_bidx = strmq_pkg::SPAN_W'(r_reg) + 1'b1
                  - (strmq_pkg::SPAN_W'(1) << p_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            strmq_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (opcode)
                        strmq_pkg::OP_BUILD:
                        begin
                            state_next = (n_eff == '0) ? strmq_pkg::S_FINISH
                                                       : strmq_pkg::S_B0_RD;
                        end
                        strmq_pkg::OP_QUERY: state_next = strmq_pkg::S_Q_CHK;
                        default:             state_next = strmq_pkg::S_FINISH;
                    endcase
                end
            end
            strmq_pkg::S_B0_RD:  state_next = strmq_pkg::S_B0_WR;
            strmq_pkg::S_B0_WR:
            begin
                state_next = b0_more ? strmq_pkg::S_B0_RD : strmq_pkg::S_LVL;
            end
            strmq_pkg::S_LVL:
            begin
                state_next = lvl_go ? strmq_pkg::S_BK_RDA : strmq_pkg::S_FINISH;
            end
            strmq_pkg::S_BK_RDA: state_next = strmq_pkg::S_BK_RDB;
            strmq_pkg::S_BK_RDB: state_next = strmq_pkg::S_BK_WR;
            strmq_pkg::S_BK_WR:
            begin
                state_next = bk_more ? strmq_pkg::S_BK_RDA : strmq_pkg::S_LVL;
            end
            strmq_pkg::S_Q_CHK:
            begin
                state_next = q_bad ? strmq_pkg::S_FINISH : strmq_pkg::S_Q_RDA;
            end
            strmq_pkg::S_Q_RDA:  state_next = strmq_pkg::S_Q_RDB;
            strmq_pkg::S_Q_RDB:  state_next = strmq_pkg::S_Q_CMP;
            strmq_pkg::S_Q_CMP:  state_next = strmq_pkg::S_FINISH;
            strmq_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = strmq_pkg::S_IDLE;
                end
            end
            default:             state_next = strmq_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: table strobes and addresses
    always_comb
    begin
        ctrl     = '0;
        in_stall = 1'b1;
        rd_level = LW'(k_reg - 1'b1);
        rd_idx   = AW'(i_reg);
        wr_level = LW'(k_reg);
        unique case (state_reg)
            strmq_pkg::S_IDLE:   in_stall = 1'b0;
            strmq_pkg::S_B0_WR:
            begin
                ctrl.wr_en = 1'b1;
                wr_level   = '0;
            end
            strmq_pkg::S_BK_RDA: ctrl.rd_en = 1'b1;
            strmq_pkg::S_BK_RDB:
            begin
                ctrl.rd_en = 1'b1;
                ctrl.cap_a = 1'b1;
                rd_idx     = AW'(SW'(i_reg) + (span_reg >> 1));
            end
            strmq_pkg::S_BK_WR:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wr_min = 1'b1;
            end
            strmq_pkg::S_Q_RDA:
            begin
                ctrl.rd_en = 1'b1;
                rd_level   = p_reg;
                rd_idx     = AW'(l_reg);
            end
            strmq_pkg::S_Q_RDB:
            begin
                ctrl.rd_en = 1'b1;
                ctrl.cap_a = 1'b1;
                rd_level   = p_reg;
                rd_idx     = bidx_reg;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= strmq_pkg::S_IDLE;
            length_reg    <= strmq_pkg::LEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                length_reg <= cfg_wr_data;
            end
            if (state_reg == strmq_pkg::S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers and loop counters
    always_ff @(posedge clk)
    begin
        case (state_reg)
            strmq_pkg::S_IDLE:
            begin
                i_reg       <= '0;
                k_reg       <= KW'(1);
                span_reg    <= SW'(2);
                l_reg       <= index;
                r_reg       <= right_bound;
                res_min_reg <= '0;
                res_sts_reg <= strmq_pkg::STS_ACK;
            end
            strmq_pkg::S_B0_WR:
            begin
                i_reg <= b0_more ? CW'(i_reg + 1'b1) : '0;
            end
            strmq_pkg::S_BK_WR:
            begin
                if (bk_more)
                begin
                    i_reg <= CW'(i_reg + 1'b1);
                end
                else
                begin
                    i_reg    <= '0;
                    k_reg    <= KW'(k_reg + 1'b1);
                    span_reg <= span_reg << 1;
                end
            end
            strmq_pkg::S_Q_CHK:
            begin
                p_reg <= q_lvl;
                if (q_bad)
                begin
                    res_sts_reg <= strmq_pkg::STS_BAD;
                end
            end
            strmq_pkg::S_Q_RDA:
            begin
                bidx_reg <= AW'(q_bidx);
            end
            strmq_pkg::S_Q_CMP:
            begin
                res_min_reg <= min_out;
                res_sts_reg <= strmq_pkg::STS_OK;
            end
            default:
            begin
            end
        endcase
        if (state_reg == strmq_pkg::S_FINISH && out_free)
        begin
            minimum_reg <= res_min_reg;
            status_reg  <= res_sts_reg;
        end
    end

    // Element store: written by load beats, read by the level-0 copy
    always_ff @(posedge clk)
    begin
        if (in_acc && opcode == strmq_pkg::OP_LOAD
            && (NW'(index) < NW'(DEPTH)))
        begin
            elem_mem[AW'(index)] <= DATA_WIDTH'(value);
        end
        if (state_reg == strmq_pkg::S_B0_RD)
        begin
            elem_q_reg <= elem_mem[AW'(i_reg)];
        end
    end

    strmq_table #(
        .DEPTH      (DEPTH),
        .LEVELS     (LEVELS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_table (
        .clk      (clk),
        .ctrl     (ctrl),
        .rd_level (rd_level),
        .rd_idx   (rd_idx),
        .wr_level (wr_level),
        .wr_idx   (AW'(i_reg)),
        .wr_data  (elem_q_reg),
        .min_out  (min_out)
    );

    assign out_valid = out_valid_reg;
    assign minimum   = signed'(strmq_pkg::VAL_W'(minimum_reg));
    assign status    = status_reg;

endmodule

[test/sparse_table_range_minimum_test.sv]
`timescale 1ns / 100ps

module sparse_table_range_minimum_test;

    localparam int DEPTH      = 1024;
    localparam int LEVELS     = 11;
    localparam int ITEM_GOAL  = 1650;
    localparam int QUIET_MARK = 1450;
    localparam int IDLE_LIMIT = 150000;

    // opcode 3 has no function; the block just acknowledges it
    localparam logic [strmq_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic signed [strmq_pkg::VAL_W-1:0] minimum;
        logic [strmq_pkg::STS_W-1:0]        status;
    } rmq_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one directed step; a config row carries the length in val
    typedef struct {
        row_kind_t                          kind;
        logic [strmq_pkg::OPC_W-1:0]        opc;
        logic [strmq_pkg::POS_W-1:0]        lpos;
        logic [strmq_pkg::POS_W-1:0]        rpos;
        logic [strmq_pkg::VAL_W-1:0]        val;
        bit                                 typed;
        logic signed [strmq_pkg::VAL_W-1:0] emin;
        logic [strmq_pkg::STS_W-1:0]        ests;
    } dir_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [strmq_pkg::LEN_W-1:0]        cfg_wr_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [strmq_pkg::OPC_W-1:0]        opcode = strmq_pkg::OP_LOAD;
    logic [strmq_pkg::POS_W-1:0]        index = '0;
    logic [strmq_pkg::POS_W-1:0]        right_bound = '0;
    logic signed [strmq_pkg::VAL_W-1:0] value = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic signed [strmq_pkg::VAL_W-1:0] minimum;
    logic [strmq_pkg::STS_W-1:0]        status;

    // predictor state: element store, sparse table, length register
    logic signed [strmq_pkg::VAL_W-1:0] elem_mem [DEPTH];
    logic signed [strmq_pkg::VAL_W-1:0] level_tbl [LEVELS][DEPTH];
    logic [strmq_pkg::LEN_W-1:0]        len_reg = strmq_pkg::LEN_W'(1);

    // which elements hold a value, and the largest length ever built
    bit          loaded [DEPTH];
    int          built_max = 0;

    rmq_result_t pending_results [$];
    dir_row_t    dir_rows [$];

    int  failures = 0;
    int  items_sent = 0;
    int  queries_sent = 0;
    int  builds_sent = 0;
    int  results_checked = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  quiet = 1'b0;

    sparse_table_range_minimum dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .index       (index),
        .right_bound (right_bound),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .minimum     (minimum),
        .status      (status)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // range-minimum predictor; updates its own store and table
    function automatic rmq_result_t predict_rmq(logic [strmq_pkg::OPC_W-1:0] opc,
                                                logic [strmq_pkg::POS_W-1:0] lpos,
                                                logic [strmq_pkg::POS_W-1:0] rpos,
                                                logic signed [strmq_pkg::VAL_W-1:0] val);
        rmq_result_t                        res;
        int                                 n;
        int                                 span;
        int                                 p;
        logic signed [strmq_pkg::VAL_W-1:0] a;
        logic signed [strmq_pkg::VAL_W-1:0] b;
        res.minimum = '0;
        res.status  = strmq_pkg::STS_ACK;
        n = (len_reg > DEPTH) ? DEPTH : int'(len_reg);
        case (opc)
            strmq_pkg::OP_LOAD:
            begin
                elem_mem[lpos] = val;
            end
            strmq_pkg::OP_BUILD:
            begin
                for (int i = 0; i < n; i++)
                    level_tbl[0][i] = elem_mem[i];
                for (int k = 1; k < LEVELS && (1 << k) <= n; k++)
                begin
                    for (int i = 0; i + (1 << k) <= n; i++)
                    begin
                        a = level_tbl[k-1][i];
                        b = level_tbl[k-1][i + (1 << (k-1))];
                        level_tbl[k][i] = (b < a) ? b : a;
                    end
                end
            end
            strmq_pkg::OP_QUERY:
            begin
                if (lpos > rpos || int'(rpos) >= n)
                    res.status = strmq_pkg::STS_BAD;
                else
                begin
                    span = int'(rpos) - int'(lpos) + 1;
                    p = 0;
                    while ((2 << p) <= span)
                        p++;
                    if (p > LEVELS - 1)
                        p = LEVELS - 1;
                    a = level_tbl[p][lpos];
                    b = level_tbl[p][int'(rpos) + 1 - (1 << p)];
                    res.minimum = (b < a) ? b : a;
                    res.status  = strmq_pkg::STS_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // drive one input beat, wait for it to be taken, queue its result
    task automatic issue_item(logic [strmq_pkg::OPC_W-1:0] opc,
                              logic [strmq_pkg::POS_W-1:0] lpos,
                              logic [strmq_pkg::POS_W-1:0] rpos,
                              logic signed [strmq_pkg::VAL_W-1:0] val,
                              bit typed, rmq_result_t fixed);
        int          gap;
        int          n;
        rmq_result_t res;
        gap = (tx_idle_on && !quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= opc;
        index       <= lpos;
        right_bound <= rpos;
        value       <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_rmq(opc, lpos, rpos, val);
        pending_results.push_back(typed ? fixed : res);
        n = (len_reg > DEPTH) ? DEPTH : int'(len_reg);
        if (opc == strmq_pkg::OP_LOAD)
            loaded[lpos] = 1'b1;
        if (opc == strmq_pkg::OP_BUILD)
        begin
            builds_sent++;
            if (n > built_max)
                built_max = n;
        end
        if (opc == strmq_pkg::OP_QUERY)
            queries_sent++;
        if (opc != OP_UNUSED)
            items_sent++;
    endtask

    // write the length register once the block has drained
    task automatic set_length(logic [strmq_pkg::LEN_W-1:0] len);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        len_reg = len;
    endtask

    function automatic logic signed [strmq_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2, 3: return $signed($urandom_range(0, 20)) - 10;
            default: return $urandom;
        endcase
    endfunction

    // one random item of the mixed stream within a phase
    task automatic random_item(int n);
        int          sel;
        int          qn;
        int          lpos;
        int          rpos;
        int          pmax;
        rmq_result_t none;
        none = '{minimum: '0, status: strmq_pkg::STS_ACK};
        qn = (n < built_max) ? n : built_max;
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            lpos = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                        : $urandom_range(0, DEPTH - 1);
            issue_item(strmq_pkg::OP_LOAD, strmq_pkg::POS_W'(lpos),
                       strmq_pkg::POS_W'($urandom), pick_value(), 1'b0, none);
        end
        else if (sel < 20)
            issue_item(strmq_pkg::OP_BUILD, strmq_pkg::POS_W'($urandom),
                       strmq_pkg::POS_W'($urandom), $urandom, 1'b0, none);
        else if (sel < 23)
            issue_item(OP_UNUSED, strmq_pkg::POS_W'($urandom),
                       strmq_pkg::POS_W'($urandom), $urandom, 1'b0, none);
        else if (sel < 85 && qn > 0)
        begin
            lpos = $urandom_range(0, qn - 1);
            if ($urandom_range(0, 3) == 0)
            begin
                // span of an exact power of two
                pmax = 0;
                while ((2 << pmax) <= qn - lpos)
                    pmax++;
                rpos = lpos + (1 << $urandom_range(0, pmax)) - 1;
            end
            else
                rpos = $urandom_range(lpos, qn - 1);
            issue_item(strmq_pkg::OP_QUERY, strmq_pkg::POS_W'(lpos),
                       strmq_pkg::POS_W'(rpos), $urandom, 1'b0, none);
        end
        else
        begin
            // bad range: past the length, or reversed bounds
            if (n < DEPTH && $urandom_range(0, 1) == 0)
            begin
                rpos = $urandom_range(n, DEPTH - 1);
                lpos = $urandom_range(0, DEPTH - 1);
            end
            else
            begin
                lpos = $urandom_range(1, DEPTH - 1);
                rpos = $urandom_range(0, lpos - 1);
            end
            issue_item(strmq_pkg::OP_QUERY, strmq_pkg::POS_W'(lpos),
                       strmq_pkg::POS_W'(rpos), $urandom, 1'b0, none);
        end
    endtask

    // result beats against the oldest expectation
    always @(posedge clk)
    begin
        rmq_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: minimum %0d status %0d",
                       minimum, status);
                failures++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (minimum !== exp_res.minimum)
                begin
                    $error("minimum: expected %0d, got %0d", exp_res.minimum, minimum);
                    failures++;
                end
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    failures++;
                end
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (rx_idle_on && !quiet && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 14);
        out_stall <= (stall_left > 0);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("sparse_table_range_minimum_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        rmq_result_t fixed;
        rmq_result_t none;
        int          n;
        int          len;
        int          ph;
        int          mix;
        none = '{minimum: '0, status: strmq_pkg::STS_ACK};

        // directed steps, length 1 out of reset
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 1, 0, 0,
                             1, 0, strmq_pkg::STS_BAD});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 0, 1023, 32'hffff_ffff,
                             1, 0, strmq_pkg::STS_BAD});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_LOAD, 0, 1023, 32'h8000_0000,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_BUILD, 0, 0, 0,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 0, 0, 0,
                             1, 32'sh8000_0000, strmq_pkg::STS_OK});
        dir_rows.push_back('{ROW_ITEM, OP_UNUSED, 1023, 1023, 32'hffff_ffff,
                             1, 0, strmq_pkg::STS_ACK});
        // zero length: build writes nothing, every query is out of range
        dir_rows.push_back('{ROW_CFG, strmq_pkg::OP_LOAD, 0, 0, 0,
                             0, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_BUILD, 0, 0, 0,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 0, 0, 0,
                             1, 0, strmq_pkg::STS_BAD});
        dir_rows.push_back('{ROW_CFG, strmq_pkg::OP_LOAD, 0, 0, 4,
                             0, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_LOAD, 1, 0, 32'h7fff_ffff,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_LOAD, 2, 0, 5,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_LOAD, 3, 0, 32'hffff_fffd,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_LOAD, 1023, 0, 32'h7fff_ffff,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_BUILD, 0, 0, 0,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 0, 3, 0,
                             0, 0, strmq_pkg::STS_OK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 1, 2, 0,
                             0, 0, strmq_pkg::STS_OK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 3, 3, 0,
                             0, 0, strmq_pkg::STS_OK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 1, 3, 0,
                             0, 0, strmq_pkg::STS_OK});
        // load after build leaves the table stale
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_LOAD, 3, 0, 32'h7fff_ffff,
                             1, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 2, 3, 0,
                             0, 0, strmq_pkg::STS_OK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 3, 4, 0,
                             1, 0, strmq_pkg::STS_BAD});
        // length above depth saturates
        dir_rows.push_back('{ROW_CFG, strmq_pkg::OP_LOAD, 0, 0, 2047,
                             0, 0, strmq_pkg::STS_ACK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 0, 3, 0,
                             0, 0, strmq_pkg::STS_OK});
        dir_rows.push_back('{ROW_ITEM, strmq_pkg::OP_QUERY, 1023, 1022, 0,
                             1, 0, strmq_pkg::STS_BAD});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                set_length(dir_rows[i].val[strmq_pkg::LEN_W-1:0]);
            else
            begin
                fixed = '{minimum: dir_rows[i].emin, status: dir_rows[i].ests};
                issue_item(dir_rows[i].opc, dir_rows[i].lpos, dir_rows[i].rpos,
                           dir_rows[i].val, dir_rows[i].typed, fixed);
            end
        end

        // random phases: set length, fill missing elements, build unless the table is reused, then mix
        ph = 0;
        while (items_sent < ITEM_GOAL || ph < 10)
        begin
            if (ph == 2)
                len = 0;
            else if (ph == 4)
                len = 2047;
            else if (ph == 8)
                len = 1024;
            else if ($urandom_range(0, 5) == 0)
                len = $urandom_range(1, 3);
            else
                len = $urandom_range(4, 48);
            quiet = (items_sent >= QUIET_MARK);
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            set_length(strmq_pkg::LEN_W'(len));
            n = (len > DEPTH) ? DEPTH : len;
            for (int i = 0; i < n; i++)
                if (!loaded[i])
                    issue_item(strmq_pkg::OP_LOAD, strmq_pkg::POS_W'(i),
                               strmq_pkg::POS_W'($urandom), pick_value(), 1'b0, none);
            // a shorter length may reuse the table already built
            if (!(n <= built_max && $urandom_range(0, 3) == 0))
                issue_item(strmq_pkg::OP_BUILD, strmq_pkg::POS_W'($urandom),
                           strmq_pkg::POS_W'($urandom), $urandom, 1'b0, none);
            mix = $urandom_range(20, 50);
            repeat (mix)
                random_item(n);
            ph++;
        end

        quiet = 1'b1;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("ran %0d items over %0d phases: %0d queries, %0d builds",
                 items_sent, ph, queries_sent, builds_sent);
        $display("checked %0d results, lengths 0 through 2047", results_checked);
        if (failures == 0)
            $display("sparse_table_range_minimum_test: done, clean");
        else
            $display("sparse_table_range_minimum_test: done, errors");
        $finish;
    end

endmodule
